// File: rtl/unique_value_list_engine_assert.svh
// assertion macros used by the list engine controller
`ifndef UNIQUE_VALUE_LIST_ENGINE_ASSERT_SVH
`define UNIQUE_VALUE_LIST_ENGINE_ASSERT_SVH

// same-cycle implication, disabled while reset is low
`define UVL_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while reset is low
`define UVL_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/uvl_pkg.sv
// shared constants and types of the unique value list engine
`timescale 1ns / 1ps
`default_nettype none

package uvl_pkg;

    localparam int CAPACITY = 16;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int VAL_W    = 32;
    localparam int FUNC_W   = 3;
    localparam int STAT_W   = 3;
    localparam int POS_W    = 4;
    localparam int CNTO_W   = 5;

    typedef enum logic [FUNC_W-1:0] {
        FN_SEARCH   = 3'd0,
        FN_PUSH_FRT = 3'd1,
        FN_PUSH_BCK = 3'd2,
        FN_SORTED   = 3'd3,
        FN_POP_FRT  = 3'd4,
        FN_POP_BCK  = 3'd5,
        FN_REMOVE   = 3'd6
    } t_func;

    typedef enum logic [STAT_W-1:0] {
        ST_OK      = 3'd0,
        ST_DUP     = 3'd1,
        ST_EMPTY   = 3'd2,
        ST_MISSING = 3'd3,
        ST_FULL    = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        MODE_HOLD,
        MODE_LOAD,
        MODE_FROM_LEFT,
        MODE_FROM_RIGHT
    } t_mode;

    typedef struct packed {
        logic  cmp;
        t_mode mode;
    } t_cell_ctl;

    typedef struct packed {
        logic eq;
        logic lt;
    } t_flag;

endpackage

`default_nettype wire

// File: rtl/uvl_if.sv
// valid/ready channel interfaces for operation beats and result beats
`timescale 1ns / 1ps
`default_nettype none

interface uvl_item_if import uvl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [FUNC_W-1:0]        func;
    logic signed [VAL_W-1:0]  value_in;

    modport source (output valid, output func, output value_in, input ready);
    modport sink   (input valid, input func, input value_in, output ready);
endinterface

interface uvl_result_if import uvl_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [STAT_W-1:0]        status;
    logic signed [VAL_W-1:0]  value_out;
    logic [POS_W-1:0]         found_pos;
    logic [CNTO_W-1:0]        entry_count;

    modport source (output valid, output status, output value_out, output found_pos,
                    output entry_count, input ready);
    modport sink   (input valid, input status, input value_out, input found_pos,
                    input entry_count, output ready);
endinterface

`default_nettype wire

// File: rtl/uvl_cell.sv
// one list cell: holds an entry, compares it to the key, shifts to neighbors
`timescale 1ns / 1ps
`default_nettype none

module uvl_cell import uvl_pkg::*; (
    input  wire                     i_clk,
    input  wire t_cell_ctl          i_ctl,
    input  wire signed [VAL_W-1:0]  i_key,
    input  wire signed [VAL_W-1:0]  i_new,
    input  wire signed [VAL_W-1:0]  i_left,
    input  wire signed [VAL_W-1:0]  i_right,
    output logic signed [VAL_W-1:0] o_entry,
    output t_flag                   o_flag
);

    logic signed [VAL_W-1:0] r_entry;
    logic signed [VAL_W-1:0] n_entry;
    t_flag                   r_flag;

    always_comb begin
        case (i_ctl.mode)
            MODE_HOLD:       n_entry = r_entry;
            MODE_LOAD:       n_entry = i_new;
            MODE_FROM_LEFT:  n_entry = i_left;
            MODE_FROM_RIGHT: n_entry = i_right;
            default:         n_entry = r_entry;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
        if (i_ctl.cmp) begin
            r_flag.eq <= (r_entry == i_key);
            r_flag.lt <= (r_entry < i_key);
        end
    end

    assign o_entry = r_entry;
    assign o_flag  = r_flag;

endmodule

`default_nettype wire

// File: rtl/uvl_ctrl.sv
// list controller: fill count, operation decode, cell steering, result register
`timescale 1ns / 1ps
`default_nettype none
`include "unique_value_list_engine_assert.svh"

module uvl_ctrl import uvl_pkg::*; (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    uvl_item_if.sink                i_in,
    uvl_result_if.source            o_out,
    input  wire t_flag              i_flag  [CAPACITY],
    input  wire signed [VAL_W-1:0]  i_entry [CAPACITY],
    output t_cell_ctl               o_ctl   [CAPACITY],
    output logic signed [VAL_W-1:0] o_value
);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state                  r_state;
    t_func                   r_func;
    logic signed [VAL_W-1:0] r_value;
    logic [CNT_W-1:0]        r_count;
    logic                    r_out_valid;
    logic [STAT_W-1:0]       r_status;
    logic signed [VAL_W-1:0] r_vout;
    logic [POS_W-1:0]        r_pos;
    logic [CNTO_W-1:0]       r_cnt_out;

    logic [STAT_W-1:0]       n_status;
    logic signed [VAL_W-1:0] n_vout;
    logic [POS_W-1:0]        n_pos;
    logic [CNT_W-1:0]        n_count;

    logic                    w_accept;
    logic                    w_out_free;
    logic                    w_commit;
    logic [CAPACITY-1:0]     w_occ;
    logic [CAPACITY-1:0]     w_eqq;
    logic [CAPACITY-1:0]     w_ltq;
    logic [CAPACITY-1:0]     w_sort_keep;
    logic [CAPACITY-1:0]     w_rm_keep;
    logic [CAPACITY-1:0]     w_keep;
    logic                    w_hit;
    logic                    w_full;
    logic                    w_empty;
    logic                    w_ins;
    logic                    w_del;
    logic [IDX_W-1:0]        w_hit_idx;
    logic [31:0]             w_pos32;
    logic [31:0]             w_cnt32;
    logic signed [VAL_W-1:0] w_back_val;
    t_mode                   w_mode [CAPACITY];

    assign w_accept   = i_in.valid && i_in.ready;
    assign w_out_free = !r_out_valid || o_out.ready;
    assign w_commit   = (r_state == S_EXEC) && w_out_free;

    // occupancy and qualified compare flags, count is unchanged since the compare
    always_comb begin
        w_hit_idx  = '0;
        w_back_val = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            w_occ[i] = (CNT_W'(i) < r_count);
            w_eqq[i] = w_occ[i] && i_flag[i].eq;
            w_ltq[i] = w_occ[i] && i_flag[i].lt;
            if (w_eqq[i]) begin
                w_hit_idx = w_hit_idx | IDX_W'(i);
            end
        end
        for (int i = 0; i < CAPACITY; i++) begin
            // last occupied cell feeds pop back
            if (w_occ[i] && ((i == CAPACITY - 1) || !w_occ[(i + 1) % CAPACITY])) begin
                w_back_val = w_back_val | i_entry[i];
            end
        end
    end

    // cell i stays put when every cell up to it is below the value (sorted insert)
    // or when no match lies at or before it (remove)
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_sort_keep[i] = 1'b1;
            w_rm_keep[i]   = 1'b1;
            for (int j = 0; j < CAPACITY; j++) begin
                if (j <= i) begin
                    w_sort_keep[i] = w_sort_keep[i] & w_ltq[j];
                    w_rm_keep[i]   = w_rm_keep[i] & !w_eqq[j];
                end
            end
        end
    end

    assign w_hit   = |w_eqq;
    assign w_full  = (r_count == CNT_W'(CAPACITY));
    assign w_empty = (r_count == '0);

    always_comb begin
        n_status = ST_OK;
        n_vout   = '0;
        n_pos    = '0;
        n_count  = r_count;
        w_ins    = 1'b0;
        w_del    = 1'b0;
        w_keep   = '1;
        w_pos32  = 32'(w_hit_idx);
        case (r_func)
            FN_SEARCH: begin
                if (w_hit) begin
                    n_pos = w_pos32[POS_W-1:0];
                end else begin
                    n_status = ST_MISSING;
                end
            end
            FN_PUSH_FRT, FN_PUSH_BCK, FN_SORTED: begin
                if (w_hit) begin
                    n_status = ST_DUP;
                end else if (w_full) begin
                    n_status = ST_FULL;
                end else begin
                    w_ins   = 1'b1;
                    n_count = r_count + CNT_W'(1);
                    if (r_func == FN_PUSH_FRT) begin
                        w_keep = '0;
                    end else if (r_func == FN_PUSH_BCK) begin
                        w_keep = w_occ;
                    end else begin
                        w_keep = w_sort_keep;
                    end
                end
            end
            FN_POP_FRT, FN_POP_BCK: begin
                if (w_empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_count = r_count - CNT_W'(1);
                    if (r_func == FN_POP_FRT) begin
                        n_vout = i_entry[0];
                        w_del  = 1'b1;
                        w_keep = '0;
                    end else begin
                        n_vout = w_back_val;
                    end
                end
            end
            FN_REMOVE: begin
                if (w_hit) begin
                    w_del   = 1'b1;
                    w_keep  = w_rm_keep;
                    n_count = r_count - CNT_W'(1);
                end else begin
                    n_status = ST_MISSING;
                end
            end
            default: ;
        endcase
        w_cnt32 = 32'(n_count);
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            w_mode[i] = MODE_HOLD;
            if (w_commit && !w_keep[i]) begin
                if (w_del) begin
                    w_mode[i] = MODE_FROM_RIGHT;
                end else if (w_ins) begin
                    // first cell past the kept prefix takes the new value
                    if (i == 0) begin
                        w_mode[i] = MODE_LOAD;
                    end else if (w_keep[(i + CAPACITY - 1) % CAPACITY]) begin
                        w_mode[i] = MODE_LOAD;
                    end else begin
                        w_mode[i] = MODE_FROM_LEFT;
                    end
                end
            end
            o_ctl[i].cmp  = w_accept;
            o_ctl[i].mode = w_mode[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_commit) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_state <= S_EXEC;
                        r_func  <= t_func'(i_in.func);
                        r_value <= i_in.value_in;
                    end
                end
                S_EXEC: begin
                    if (w_out_free) begin
                        r_state     <= S_IDLE;
                        r_count     <= n_count;
                        r_status    <= n_status;
                        r_vout      <= n_vout;
                        r_pos       <= n_pos;
                        r_cnt_out   <= w_cnt32[CNTO_W-1:0];
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_state == S_IDLE);
    assign o_out.valid       = r_out_valid;
    assign o_out.status      = r_status;
    assign o_out.value_out   = r_vout;
    assign o_out.found_pos   = r_pos;
    assign o_out.entry_count = r_cnt_out;
    assign o_value           = r_value;

    `UVL_ASSERT_NOW(a_count_max, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(CAPACITY), "fill count above capacity")
    `UVL_ASSERT_NOW(a_unique, i_clk, i_rst_n, r_state == S_EXEC, $countones(w_eqq) <= 1, "value held twice")
    `UVL_ASSERT_NEXT(a_accept_exec, i_clk, i_rst_n, w_accept, r_state == S_EXEC, "accepted beat not executed")
    `UVL_ASSERT_NOW(a_count_commit, i_clk, i_rst_n, !$stable(r_count), $past(r_state == S_EXEC), "count moved outside execute")

endmodule

`default_nettype wire

// File: rtl/unique_value_list_engine.sv
// top level of the unique value list engine: controller plus a row of list cells
//
//  channel   dir  payload                                    handshake
//  i_item    in   func, value_in                             valid / ready
//  o_result  out  status, value_out, found_pos, entry_count  valid / ready
//
// the accept edge latches the compare flags in all cells at once; in the
// execute state, once the output register is free, the cells shift and the
// result beat loads. i_item.ready is high only while no operation is in flight;
// a stalled result holds the execute state until the output register is free.
// reset empties the list at once; cell contents are not cleared.
`timescale 1ns / 1ps
`default_nettype none

module unique_value_list_engine import uvl_pkg::*; (
    input  wire          i_clk,
    input  wire          i_rst_n,
    uvl_item_if.sink     i_item,
    uvl_result_if.source o_result
);

    t_cell_ctl               w_ctl   [CAPACITY];
    t_flag                   w_flag  [CAPACITY];
    logic signed [VAL_W-1:0] w_entry [CAPACITY];
    logic signed [VAL_W-1:0] w_value;

    uvl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_item),
        .o_out   (o_result),
        .i_flag  (w_flag),
        .i_entry (w_entry),
        .o_ctl   (w_ctl),
        .o_value (w_value)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic signed [VAL_W-1:0] w_left;
        logic signed [VAL_W-1:0] w_right;

        if (g == 0) begin : g_first
            assign w_left = w_value;
        end else begin : g_mid_l
            assign w_left = w_entry[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right = w_entry[g];
        end else begin : g_mid_r
            assign w_right = w_entry[g+1];
        end

        uvl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctl   (w_ctl[g]),
            .i_key   (i_item.value_in),
            .i_new   (w_value),
            .i_left  (w_left),
            .i_right (w_right),
            .o_entry (w_entry[g]),
            .o_flag  (w_flag[g])
        );
    end

endmodule

`default_nettype wire

// File: verif/tb_unique_value_list_engine.sv
// testbench for the unique value list engine: directed table, then random traffic checked against a list predictor
`timescale 1ns / 1ps

module tb_unique_value_list_engine;
    import uvl_pkg::*;

    localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;
    localparam logic [VAL_W-1:0]  V_MIN = 32'h8000_0000;
    localparam logic [VAL_W-1:0]  V_MAX = 32'h7fff_ffff;
    localparam logic [VAL_W-1:0]  V_NEG1 = 32'hffff_ffff;
    localparam logic [VAL_W-1:0]  EXTREME_VALS [7] = '{V_MIN, V_MIN + 1, V_NEG1, 32'd0, 32'd1,
                                                        V_MAX - 1, V_MAX};
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL_CYCLES = 8;
    localparam int PHASE_OPS = 138;
    localparam int DIR_ROWS_N = 14;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [VAL_W-1:0]  value_out;
        logic [POS_W-1:0]  found_pos;
        logic [CNTO_W-1:0] entry_count;
    } result_t;

    typedef struct packed {
        logic [FUNC_W-1:0] fn;
        logic [VAL_W-1:0]  val;
        logic              has_exp;
        result_t           exp;
    } stim_row_t;

    // expected results typed in only where they follow at a glance
    localparam stim_row_t DIR_ROWS [DIR_ROWS_N] = '{
        '{FN_POP_FRT,  32'd0,  1'b1, '{ST_EMPTY,   32'd0, 4'd0, 5'd0}},
        '{FN_POP_BCK,  32'd0,  1'b1, '{ST_EMPTY,   32'd0, 4'd0, 5'd0}},
        '{FN_SEARCH,   32'd0,  1'b1, '{ST_MISSING, 32'd0, 4'd0, 5'd0}},
        '{FN_REMOVE,   32'd0,  1'b1, '{ST_MISSING, 32'd0, 4'd0, 5'd0}},
        '{FN_UNUSED,   V_MAX,  1'b1, '{ST_OK,      32'd0, 4'd0, 5'd0}},
        '{FN_PUSH_BCK, V_MAX,  1'b1, '{ST_OK,      32'd0, 4'd0, 5'd1}},
        '{FN_POP_BCK,  32'd0,  1'b1, '{ST_OK,      V_MAX, 4'd0, 5'd0}},
        '{FN_PUSH_FRT, V_MIN,  1'b1, '{ST_OK,      32'd0, 4'd0, 5'd1}},
        '{FN_SORTED,   V_MAX,  1'b0, '0},
        '{FN_SORTED,   V_NEG1, 1'b0, '0},
        '{FN_PUSH_BCK, V_NEG1, 1'b1, '{ST_DUP,     32'd0, 4'd0, 5'd3}},
        '{FN_SEARCH,   V_MAX,  1'b0, '0},
        '{FN_REMOVE,   V_NEG1, 1'b0, '0},
        '{FN_POP_FRT,  32'd0,  1'b0, '0}
    };

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    uvl_item_if   op_ch ();
    uvl_result_if res_ch ();

    unique_value_list_engine uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (op_ch),
        .o_result (res_ch)
    );

    always #1 i_clk = ~i_clk;

    // predictor state and the results still owed by the block
    logic signed [VAL_W-1:0] held_q [$];
    result_t                 owed_q [$];

    // travels with each beat: a typed-in expectation replaces the predicted one
    logic    beat_has_exp = 1'b0;
    result_t beat_exp = '0;

    int gap_pct = 0;
    int stall_pct = 0;
    int err_count = 0;
    int n_ops = 0;
    int n_results = 0;
    int n_full = 0;
    int n_dup = 0;
    int n_empty = 0;
    int n_missing = 0;
    int idle_cycles = 0;

    function automatic result_t apply_op(logic [FUNC_W-1:0] fn, logic signed [VAL_W-1:0] v);
        result_t r;
        int      idx;
        int      pos;
        r = '0;
        idx = -1;
        for (int i = 0; i < held_q.size(); i++) begin
            if (idx < 0 && held_q[i] == v) begin
                idx = i;
            end
        end
        case (fn)
            FN_SEARCH: begin
                if (idx >= 0) r.found_pos = POS_W'(idx);
                else r.status = ST_MISSING;
            end
            FN_PUSH_FRT, FN_PUSH_BCK, FN_SORTED: begin
                if (idx >= 0) begin
                    r.status = ST_DUP;
                end else if (held_q.size() >= CAPACITY) begin
                    r.status = ST_FULL;
                end else if (fn == FN_PUSH_FRT) begin
                    held_q.push_front(v);
                end else if (fn == FN_PUSH_BCK) begin
                    held_q.push_back(v);
                end else begin
                    // goes ahead of the first entry not below it
                    pos = 0;
                    while (pos < held_q.size() && held_q[pos] < v) pos++;
                    held_q.insert(pos, v);
                end
            end
            FN_POP_FRT, FN_POP_BCK: begin
                if (held_q.size() == 0) r.status = ST_EMPTY;
                else if (fn == FN_POP_FRT) r.value_out = held_q.pop_front();
                else r.value_out = held_q.pop_back();
            end
            FN_REMOVE: begin
                if (idx >= 0) held_q.delete(idx);
                else r.status = ST_MISSING;
            end
            default: ;
        endcase
        r.entry_count = CNTO_W'(held_q.size());
        return r;
    endfunction

    function automatic logic [FUNC_W-1:0] choose_op(bit grow);
        int r;
        r = $urandom_range(0, 99);
        if (r < 2) return FN_UNUSED;
        if (r < 16) return FN_SEARCH;
        if (grow) begin
            if (r < 34) return FN_PUSH_FRT;
            if (r < 52) return FN_PUSH_BCK;
            if (r < 76) return FN_SORTED;
            if (r < 84) return FN_POP_FRT;
            if (r < 90) return FN_POP_BCK;
            return FN_REMOVE;
        end
        if (r < 22) return FN_PUSH_FRT;
        if (r < 28) return FN_PUSH_BCK;
        if (r < 36) return FN_SORTED;
        if (r < 60) return FN_POP_FRT;
        if (r < 82) return FN_POP_BCK;
        return FN_REMOVE;
    endfunction

    // held values often, so duplicates, hits and removals happen
    function automatic logic [VAL_W-1:0] pick_value();
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 35 && held_q.size() != 0) return held_q[$urandom_range(0, held_q.size() - 1)];
        if (sel < 50) return EXTREME_VALS[$urandom_range(0, 6)];
        if (sel < 75) return $urandom_range(0, 40) - 20;
        return $urandom;
    endfunction

    task automatic send_beat(logic [FUNC_W-1:0] fn, logic [VAL_W-1:0] v, logic has_exp,
                             result_t exp);
        while ($urandom_range(0, 99) < gap_pct) begin
            op_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        op_ch.valid <= 1'b1;
        op_ch.func <= fn;
        op_ch.value_in <= v;
        beat_has_exp <= has_exp;
        beat_exp <= exp;
        do @(posedge i_clk); while (!op_ch.ready);
    endtask

    // sender stays idle until every owed result has come back
    task automatic hold_off();
        op_ch.valid <= 1'b0;
        do @(posedge i_clk); while (owed_q.size() != 0);
    endtask

    task automatic check_field(string name, logic [VAL_W-1:0] exp, logic [VAL_W-1:0] act);
        if (exp !== act) begin
            $error("%s mismatch: expected 0x%08h, got 0x%08h", name, exp, act);
            err_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) res_ch.ready <= 1'b0;
        else res_ch.ready <= ($urandom_range(0, 99) >= stall_pct);
    end

    // accepted beats on both channels: predict on the op side, compare on the result side
    always @(posedge i_clk) begin
        result_t pred;
        result_t want;
        if (!i_rst_n) begin
            held_q.delete();
            owed_q.delete();
        end else begin
            if (op_ch.valid && op_ch.ready) begin
                pred = apply_op(op_ch.func, op_ch.value_in);
                owed_q.push_back(beat_has_exp ? beat_exp : pred);
                n_ops++;
            end
            if (res_ch.valid && res_ch.ready) begin
                n_results++;
                if (owed_q.size() == 0) begin
                    $error("result beat with no operation pending");
                    err_count++;
                end else begin
                    want = owed_q.pop_front();
                    check_field("status", VAL_W'(want.status), VAL_W'(res_ch.status));
                    check_field("value_out", want.value_out, res_ch.value_out);
                    check_field("found_pos", VAL_W'(want.found_pos), VAL_W'(res_ch.found_pos));
                    check_field("entry_count", VAL_W'(want.entry_count),
                                VAL_W'(res_ch.entry_count));
                    case (want.status)
                        ST_FULL:    n_full++;
                        ST_DUP:     n_dup++;
                        ST_EMPTY:   n_empty++;
                        ST_MISSING: n_missing++;
                        default: ;
                    endcase
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (op_ch.valid && op_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        int  k;
        int  ph;
        bit  grow;
        op_ch.valid = 1'b0;
        op_ch.func = '0;
        op_ch.value_in = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < DIR_ROWS_N; k++) begin
            send_beat(DIR_ROWS[k].fn, DIR_ROWS[k].val, DIR_ROWS[k].has_exp, DIR_ROWS[k].exp);
        end
        // fill to capacity, then a refused insert and a duplicate at full
        for (k = 0; k < CAPACITY - 1; k++) begin
            send_beat(FN_SORTED, k * 37 - 200, 1'b0, '0);
        end
        send_beat(FN_PUSH_FRT, 32'd12345, 1'b0, '0);
        send_beat(FN_PUSH_BCK, V_MAX, 1'b0, '0);
        hold_off();

        for (ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin gap_pct = 0;  stall_pct = 0;  end
                1: begin gap_pct = 54; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 54; end
                default: begin gap_pct = 28; stall_pct = 28; end
            endcase
            for (k = 0; k < PHASE_OPS; k++) begin
                grow = ((k / 23) % 2) == (ph % 2);
                send_beat(choose_op(grow), pick_value(), 1'b0, '0);
            end
            hold_off();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (owed_q.size() != 0) begin
            $error("%0d results never arrived", owed_q.size());
            err_count++;
        end
        $display("ran %0d operations, checked %0d results", n_ops, n_results);
        $display("refusals seen: %0d full, %0d duplicate; %0d empty pops, %0d misses",
                 n_full, n_dup, n_empty, n_missing);
        if (err_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
